>>> sv/obcd_pkg.sv
package obcd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned THR_W      = 7;
  localparam int unsigned GW_W       = 11;
  localparam int unsigned GH_W       = 13;
  localparam int unsigned STRIDE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned OUT_ROW_W  = 12;

  localparam logic [THR_W-1:0]    OCC_THR_RST  = 7'd65;
  localparam logic [THR_W-1:0]    FREE_THR_RST = 7'd20;
  localparam logic [THR_W-1:0]    THR_CAP      = 7'd100;
  localparam logic [GW_W-1:0]     GW_RST       = 11'd1024;
  localparam logic [GH_W-1:0]     GH_RST       = 13'd1024;
  localparam logic [STRIDE_W-1:0] STRIDE_RST   = 4'd1;
  localparam logic [VALUE_W-1:0]  DRAIN_VALUE  = 8'hFF;

  // divisibility check by multiply with ceil(2^RECIP_SHIFT / stride)
  localparam int unsigned DIV_W       = 16;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP_TAB [16] = '{
    21'd1048576, 21'd1048576, 21'd524288, 21'd349526,
    21'd262144,  21'd209716,  21'd174763, 21'd149797,
    21'd131072,  21'd116509,  21'd104858, 21'd95326,
    21'd87382,   21'd80660,   21'd74899,  21'd69906
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCC_THR       = 3'd0,
    CFG_FREE_THR      = 3'd1,
    CFG_BOUNDARY_ONLY = 3'd2,
    CFG_GRID_WIDTH    = 3'd3,
    CFG_GRID_HEIGHT   = 3'd4,
    CFG_SAMPLE_STRIDE = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KIND_CELL  = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef struct packed {
    logic [THR_W-1:0]    occ_thr;
    logic [THR_W-1:0]    free_thr;
    logic                boundary_only;
    logic [GW_W-1:0]     grid_width;
    logic [GH_W-1:0]     grid_height;
    logic [STRIDE_W-1:0] sample_stride;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] upper;
    logic [VALUE_W-1:0] middle;
  } line_entry_t;

endpackage

>>> sv/obcd_cfg.sv
module obcd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [obcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [obcd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output obcd_pkg::cfg_t                      cfg_o,
  output logic                                geo_wr_o
);

  obcd_pkg::cfg_t     cfg_q, cfg_d;
  obcd_pkg::cfg_idx_e idx;

  assign idx         = obcd_pkg::cfg_idx_e'(cfg_index_i);
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;
  assign geo_wr_o    = cfg_valid_i && (idx == obcd_pkg::CFG_GRID_WIDTH ||
                                       idx == obcd_pkg::CFG_GRID_HEIGHT);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (idx)
        obcd_pkg::CFG_OCC_THR:       cfg_d.occ_thr       = cfg_data_i[obcd_pkg::THR_W-1:0];
        obcd_pkg::CFG_FREE_THR:      cfg_d.free_thr      = cfg_data_i[obcd_pkg::THR_W-1:0];
        obcd_pkg::CFG_BOUNDARY_ONLY: cfg_d.boundary_only = cfg_data_i[0];
        obcd_pkg::CFG_GRID_WIDTH:    cfg_d.grid_width    = cfg_data_i[obcd_pkg::GW_W-1:0];
        obcd_pkg::CFG_GRID_HEIGHT:   cfg_d.grid_height   = cfg_data_i[obcd_pkg::GH_W-1:0];
        obcd_pkg::CFG_SAMPLE_STRIDE: cfg_d.sample_stride = cfg_data_i[obcd_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.occ_thr       <= obcd_pkg::OCC_THR_RST;
      cfg_q.free_thr      <= obcd_pkg::FREE_THR_RST;
      cfg_q.boundary_only <= 1'b1;
      cfg_q.grid_width    <= obcd_pkg::GW_RST;
      cfg_q.grid_height   <= obcd_pkg::GH_RST;
      cfg_q.sample_stride <= obcd_pkg::STRIDE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> sv/obcd_line_store.sv
module obcd_line_store #(
  parameter int unsigned MAX_WIDTH = obcd_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  obcd_pkg::line_entry_t        wr_data_i,
  output obcd_pkg::line_entry_t        rd_data_o
);

  obcd_pkg::line_entry_t mem [MAX_WIDTH];
  obcd_pkg::line_entry_t rdata_q;
  obcd_pkg::line_entry_t fwd_data_q;
  logic                  fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // same-entry write in the read cycle (one-column grid)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

>>> sv/obcd_window.sv
module obcd_window #(
  parameter int unsigned MAX_WIDTH  = obcd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = obcd_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2),
  localparam int unsigned WW  = ($clog2(MAX_WIDTH + 1) > obcd_pkg::GW_W) ?
                                $clog2(MAX_WIDTH + 1) : obcd_pkg::GW_W,
  localparam int unsigned HW  = ($clog2(MAX_HEIGHT + 1) > obcd_pkg::GH_W) ?
                                $clog2(MAX_HEIGHT + 1) : obcd_pkg::GH_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               act_i,
  input  logic [CW-1:0]                      col_i,
  input  logic [RW-1:0]                      row_i,
  input  logic [obcd_pkg::VALUE_W-1:0]       value_i,
  input  logic [WW-1:0]                      w_eff_i,
  input  logic [HW-1:0]                      h_eff_i,
  input  obcd_pkg::cfg_t                     cfg_i,
  input  obcd_pkg::line_entry_t              ent_i,
  output logic                               wr_en_o,
  output logic [CW-1:0]                      wr_addr_o,
  output obcd_pkg::line_entry_t              wr_data_o,
  output logic                               det_valid_o,
  output logic [obcd_pkg::DIV_W-1:0]         det_row_o,
  output logic [obcd_pkg::DIV_W-1:0]         det_col_o
);

  localparam int unsigned RHW = (RW > HW) ? RW : HW;
  localparam int unsigned VW  = obcd_pkg::VALUE_W;
  localparam int unsigned TW  = obcd_pkg::THR_W;

  function automatic logic is_free(input logic [VW-1:0] v, input logic [TW-1:0] thr);
    is_free = !v[VW-1] && (v[VW-2:0] <= thr);
  endfunction

  logic          s1_valid_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic [VW-1:0] s1_value_q;
  logic [VW-1:0] win_q [3][3];

  logic [VW-1:0] lft_v [3];
  logic [VW-1:0] ctr_v [3];
  logic [VW-1:0] rgt_v [3];
  logic [TW-1:0] occ_cap;
  logic [TW-1:0] free_cap;
  logic          is_a;
  logic          is_b;
  logic [RW-1:0] cr;
  logic [CW-1:0] cc;
  logic          in_grid;
  logic          top_out;
  logic          bot_out;
  logic          lft_out;
  logic          rgt_out;
  logic          occupied;
  logic          boundary;
  logic          cand;

  logic                       det_valid_q;
  logic [obcd_pkg::DIV_W-1:0] det_row_q;
  logic [obcd_pkg::DIV_W-1:0] det_col_q;

  assign occ_cap  = (cfg_i.occ_thr > obcd_pkg::THR_CAP) ? obcd_pkg::THR_CAP : cfg_i.occ_thr;
  assign free_cap = (cfg_i.free_thr > obcd_pkg::THR_CAP) ? obcd_pkg::THR_CAP : cfg_i.free_thr;

  // left and center columns come from the held window, right column is the new one
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lft_v[r] = win_q[r][1];
      ctr_v[r] = win_q[r][2];
    end
    rgt_v[0] = ent_i.upper;
    rgt_v[1] = ent_i.middle;
    rgt_v[2] = s1_value_q;
  end

  // end-of-row cell is decided at the next row's first column
  assign is_a = (s1_col_q == '0) && (s1_row_q >= RW'(2));
  assign is_b = (s1_col_q != '0) && (s1_row_q >= RW'(1));
  assign cr   = is_a ? s1_row_q - RW'(2) : s1_row_q - RW'(1);
  assign cc   = is_a ? CW'(w_eff_i - WW'(1)) : s1_col_q - CW'(1);

  assign in_grid = RHW'(cr) < RHW'(h_eff_i);
  assign top_out = (cr == '0);
  assign bot_out = (RHW'(cr) + RHW'(1)) >= RHW'(h_eff_i);
  assign lft_out = (cc == '0);
  assign rgt_out = (WW'(cc) + WW'(1)) >= w_eff_i;

  assign occupied = !ctr_v[1][VW-1] && (ctr_v[1][VW-2:0] >= occ_cap);

  assign boundary = top_out || bot_out || lft_out || rgt_out ||
                    is_free(lft_v[0], free_cap) || is_free(ctr_v[0], free_cap) ||
                    is_free(rgt_v[0], free_cap) || is_free(lft_v[1], free_cap) ||
                    is_free(rgt_v[1], free_cap) || is_free(lft_v[2], free_cap) ||
                    is_free(ctr_v[2], free_cap) || is_free(rgt_v[2], free_cap);

  assign cand = s1_valid_q && (is_a || is_b) && in_grid && occupied &&
                (!cfg_i.boundary_only || boundary);

  assign wr_en_o          = en_i && s1_valid_q;
  assign wr_addr_o        = s1_col_q;
  assign wr_data_o.upper  = ent_i.middle;
  assign wr_data_o.middle = s1_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      det_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (en_i) begin
      s1_valid_q  <= act_i;
      det_valid_q <= cand;
      if (s1_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
          win_q[r][2] <= rgt_v[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (act_i) begin
        s1_col_q   <= col_i;
        s1_row_q   <= row_i;
        s1_value_q <= value_i;
      end
      det_row_q <= obcd_pkg::DIV_W'(cr);
      det_col_q <= obcd_pkg::DIV_W'(cc);
    end
  end

  assign det_valid_o = det_valid_q;
  assign det_row_o   = det_row_q;
  assign det_col_o   = det_col_q;

endmodule

>>> sv/obcd_stride_chk.sv
module obcd_stride_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [obcd_pkg::STRIDE_W-1:0]    stride_i,
  input  logic                             det_valid_i,
  input  logic [obcd_pkg::DIV_W-1:0]       det_row_i,
  input  logic [obcd_pkg::DIV_W-1:0]       det_col_i,
  output logic                             hit_valid_o,
  output logic [obcd_pkg::OUT_COL_W-1:0]   hit_col_o,
  output logic [obcd_pkg::OUT_ROW_W-1:0]   hit_row_o
);

  localparam int unsigned XW = obcd_pkg::DIV_W;
  localparam int unsigned PW = obcd_pkg::DIV_W + obcd_pkg::RECIP_W;
  localparam int unsigned SH = obcd_pkg::RECIP_SHIFT;
  localparam int unsigned MW = obcd_pkg::DIV_W + obcd_pkg::STRIDE_W;

  logic [obcd_pkg::RECIP_W-1:0]  recip;
  logic [obcd_pkg::STRIDE_W-1:0] stride_eff;
  logic [PW-1:0]                 prod_row;
  logic [PW-1:0]                 prod_col;
  logic                          q_valid_q;
  logic [XW-1:0]                 q_row_q;
  logic [XW-1:0]                 q_col_q;
  logic [XW-1:0]                 x_row_q;
  logic [XW-1:0]                 x_col_q;
  logic [MW-1:0]                 back_row;
  logic [MW-1:0]                 back_col;

  assign recip      = obcd_pkg::RECIP_TAB[stride_i];
  assign stride_eff = (stride_i == '0) ? obcd_pkg::STRIDE_W'(1) : stride_i;
  assign prod_row   = PW'(det_row_i) * PW'(recip);
  assign prod_col   = PW'(det_col_i) * PW'(recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else if (en_i) begin
      q_valid_q <= det_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_row_q <= prod_row[SH+XW-1:SH];
      q_col_q <= prod_col[SH+XW-1:SH];
      x_row_q <= det_row_i;
      x_col_q <= det_col_i;
    end
  end

  assign back_row = MW'(q_row_q) * MW'(stride_eff);
  assign back_col = MW'(q_col_q) * MW'(stride_eff);

  assign hit_valid_o = q_valid_q && (back_row == MW'(x_row_q)) && (back_col == MW'(x_col_q));
  assign hit_col_o   = x_col_q[obcd_pkg::OUT_COL_W-1:0];
  assign hit_row_o   = x_row_q[obcd_pkg::OUT_ROW_W-1:0];

endmodule

>>> sv/obcd_out_skid.sv
module obcd_out_skid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             hit_valid_i,
  input  logic [obcd_pkg::OUT_COL_W-1:0]   hit_col_i,
  input  logic [obcd_pkg::OUT_ROW_W-1:0]   hit_row_i,
  output logic                             en_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [obcd_pkg::OUT_COL_W-1:0]   out_cell_column_o,
  output logic [obcd_pkg::OUT_ROW_W-1:0]   out_cell_row_o
);

  logic                           out_valid_q, out_valid_d;
  logic                           skid_valid_q, skid_valid_d;
  logic [obcd_pkg::OUT_COL_W-1:0] out_col_q, out_col_d, skid_col_q, skid_col_d;
  logic [obcd_pkg::OUT_ROW_W-1:0] out_row_q, out_row_d, skid_row_q, skid_row_d;
  logic                           take;

  assign take = out_valid_q && !out_stall_i;
  assign en_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    skid_col_d   = skid_col_q;
    skid_row_d   = skid_row_q;
    if (skid_valid_q) begin
      if (take) begin
        out_col_d    = skid_col_q;
        out_row_d    = skid_row_q;
        skid_valid_d = 1'b0;
      end
    end else begin
      if (take) begin
        out_valid_d = 1'b0;
      end
      if (hit_valid_i) begin
        if (!out_valid_q || take) begin
          out_valid_d = 1'b1;
          out_col_d   = hit_col_i;
          out_row_d   = hit_row_i;
        end else begin
          skid_valid_d = 1'b1;
          skid_col_d   = hit_col_i;
          skid_row_d   = hit_row_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    skid_col_q <= skid_col_d;
    skid_row_q <= skid_row_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_cell_column_o = out_col_q;
  assign out_cell_row_o    = out_row_q;

endmodule

>>> sv/occupied_boundary_cell_detector_top.sv
// Throughput: one input beat per cycle; in_stall_o rises only while the two-entry
//   output buffer is full.
// Pipeline: the input beat that completes a cell's window passes the line store read,
//   the window decision and the stride check before its result beat is valid.
// Reset: control state and position clear, registers take their defaults; line
//   store contents stay undefined, no clearing pass.
module occupied_boundary_cell_detector_top #(
  parameter int unsigned MAX_WIDTH  = obcd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = obcd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [obcd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [obcd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 in_kind_i,
  input  logic signed [obcd_pkg::VALUE_W-1:0]  in_cell_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [obcd_pkg::OUT_COL_W-1:0]       out_cell_column_o,
  output logic [obcd_pkg::OUT_ROW_W-1:0]       out_cell_row_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned DW  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned WW  = ($clog2(MAX_WIDTH + 1) > obcd_pkg::GW_W) ?
                                $clog2(MAX_WIDTH + 1) : obcd_pkg::GW_W;
  localparam int unsigned HW  = ($clog2(MAX_HEIGHT + 1) > obcd_pkg::GH_W) ?
                                $clog2(MAX_HEIGHT + 1) : obcd_pkg::GH_W;
  localparam int unsigned RHW = (RW > HW) ? RW : HW;

  obcd_pkg::cfg_t        cfg;
  obcd_pkg::line_entry_t ent;
  obcd_pkg::line_entry_t wr_data;
  logic                  geo_wr;
  logic                  en;

  logic [WW-1:0] gw_ext;
  logic [HW-1:0] gh_ext;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [DW-1:0] drain_q, drain_d;

  logic                         in_acc;
  logic                         draining;
  logic                         act;
  logic [CW-1:0]                col_cur;
  logic                         col_last;
  logic [DW-1:0]                drain_nxt;
  logic                         drain_done;
  logic [obcd_pkg::VALUE_W-1:0] value;

  logic          wr_en;
  logic [CW-1:0] wr_addr;

  logic                             det_valid;
  logic [obcd_pkg::DIV_W-1:0]       det_row;
  logic [obcd_pkg::DIV_W-1:0]       det_col;
  logic                             hit_valid;
  logic [obcd_pkg::OUT_COL_W-1:0]   hit_col;
  logic [obcd_pkg::OUT_ROW_W-1:0]   hit_row;

  obcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .geo_wr_o    (geo_wr)
  );

  assign gw_ext = WW'(cfg.grid_width);
  assign gh_ext = HW'(cfg.grid_height);

  always_comb begin
    if (cfg.grid_width == '0) begin
      w_eff = WW'(1);
    end else if (gw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = gw_ext;
    end
  end

  always_comb begin
    if (cfg.grid_height == '0) begin
      h_eff = HW'(1);
    end else if (gh_ext > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = gh_ext;
    end
  end

  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign draining   = RHW'(row_q) >= RHW'(h_eff);
  // drain beat before the frame's last cell is dropped
  assign act        = in_acc && !(obcd_pkg::kind_e'(in_kind_i) == obcd_pkg::KIND_DRAIN &&
                                  !draining);
  assign value      = draining ? obcd_pkg::DRAIN_VALUE : $unsigned(in_cell_value_i);
  assign col_cur    = (WW'(col_q) >= w_eff) ? '0 : col_q;
  assign col_last   = (WW'(col_cur) + WW'(1)) >= w_eff;
  assign drain_nxt  = drain_q + DW'(1);
  assign drain_done = draining && (drain_nxt >= DW'(w_eff) + DW'(1));

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (geo_wr) begin
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
    end else if (act) begin
      if (drain_done) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = '0;
      end else begin
        col_d = col_last ? '0 : col_cur + CW'(1);
        row_d = col_last ? row_q + RW'(1) : row_q;
        if (draining) begin
          drain_d = drain_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  obcd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (act),
    .rd_addr_i (col_cur),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (ent)
  );

  obcd_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .act_i       (act),
    .col_i       (col_cur),
    .row_i       (row_q),
    .value_i     (value),
    .w_eff_i     (w_eff),
    .h_eff_i     (h_eff),
    .cfg_i       (cfg),
    .ent_i       (ent),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .det_valid_o (det_valid),
    .det_row_o   (det_row),
    .det_col_o   (det_col)
  );

  obcd_stride_chk u_stride_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .stride_i    (cfg.sample_stride),
    .det_valid_i (det_valid),
    .det_row_i   (det_row),
    .det_col_i   (det_col),
    .hit_valid_o (hit_valid),
    .hit_col_o   (hit_col),
    .hit_row_o   (hit_row)
  );

  obcd_out_skid u_out_skid (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .hit_valid_i       (hit_valid),
    .hit_col_i         (hit_col),
    .hit_row_i         (hit_row),
    .en_o              (en),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_cell_column_o (out_cell_column_o),
    .out_cell_row_o    (out_cell_row_o)
  );

endmodule
